/* hw/rtl/rdc_pkg.sv */
// Shared constants for the radix digit converter.
package rdc_pkg;

  localparam int DEF_VALUE_BITS  = 31;
  localparam int DEF_STACK_DEPTH = 32;

  localparam int DIGIT_W = 4;
  localparam int RADIX_W = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd9;

endpackage

/* hw/rtl/radix_digit_converter_core.sv */
// Radix digit converter: bit-serial division into a digit stack, then popping MSD first.
// Each digit takes bit-serial long division by the radix, one quotient bit per cycle;
// after the last digit the top of the stack is read, and digits then leave at one per cycle
// while out_stall is low. One value is converted at a time; in_stall stays high until it is done.
// Synchronous reset clears control state and sets the radix to 2; the stack is not cleared.
module radix_digit_converter_core #(
  parameter int VALUE_BITS  = rdc_pkg::DEF_VALUE_BITS,
  parameter int STACK_DEPTH = rdc_pkg::DEF_STACK_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rdc_pkg::RADIX_W-1:0] cfg_data,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [VALUE_BITS-1:0]       value,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rdc_pkg::DIGIT_W-1:0] digit,
  output logic                        last
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int BIT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int RW     = rdc_pkg::RADIX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]            state, state_next;
  logic [RW-1:0]         radix;
  logic [VALUE_BITS-1:0] quot, quot_next;
  logic [RW-1:0]         rem, rem_next;
  logic                  nz, nz_next;
  logic [BIT_W-1:0]      bitcnt, bitcnt_next;
  logic [CNT_W-1:0]      count, count_next;

  logic [RW:0]           trial;
  logic [RW:0]           diff;
  logic                  ge;
  logic [RW-1:0]         rem_wr;
  logic                  digit_done;
  logic                  in_acc, out_acc;
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [CNT_W-1:0]      count_dec;

  assign cfg_ready = 1'b1;

  // Store the saturated radix so the divider never sees a base outside two to nine.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rdc_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data < rdc_pkg::RADIX_MIN) begin
        radix <= rdc_pkg::RADIX_MIN;
      end else if (cfg_data > rdc_pkg::RADIX_MAX) begin
        radix <= rdc_pkg::RADIX_MAX;
      end else begin
        radix <= cfg_data;
      end
    end
  end

  // One restoring-division step: bring in the next dividend bit, subtract if it fits.
  assign trial  = {rem, quot[VALUE_BITS-1]};
  assign diff   = trial - {1'b0, radix};
  assign ge     = (trial >= {1'b0, radix});
  assign rem_wr = ge ? diff[RW-1:0] : trial[RW-1:0];

  assign digit_done = (state == ST_DIV) && (bitcnt == BIT_W'(VALUE_BITS - 1));
  assign in_stall   = (state != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_valid  = (state == ST_OUT);
  assign out_acc    = out_valid && !out_stall;
  assign count_dec  = count - CNT_W'(1);
  assign last       = (count == '0);

  assign ram_we    = digit_done;
  assign ram_re    = (state == ST_RD) || (out_acc && (count != '0));
  assign ram_raddr = count_dec[ADDR_W-1:0];

  always_comb begin
    state_next  = state;
    quot_next   = quot;
    rem_next    = rem;
    nz_next     = nz;
    bitcnt_next = bitcnt;
    count_next  = count;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          quot_next   = value;
          rem_next    = '0;
          nz_next     = 1'b0;
          bitcnt_next = '0;
          count_next  = '0;
          state_next  = ST_DIV;
        end
      end
      ST_DIV: begin
        quot_next   = {quot[VALUE_BITS-2:0], ge};
        rem_next    = rem_wr;
        nz_next     = nz | ge;
        bitcnt_next = bitcnt + BIT_W'(1);
        if (digit_done) begin
          count_next  = count + CNT_W'(1);
          rem_next    = '0;
          nz_next     = 1'b0;
          bitcnt_next = '0;
          // Keep dividing while the quotient is nonzero and the stack has room.
          if (!((nz | ge) && (count != CNT_W'(STACK_DEPTH - 1)))) begin
            state_next = ST_RD;
          end
        end
      end
      ST_RD: begin
        count_next = count_dec;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc) begin
          if (count == '0) begin
            state_next = ST_IDLE;
          end else begin
            count_next = count_dec;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      bitcnt <= '0;
      nz     <= 1'b0;
      rem    <= '0;
      quot   <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      bitcnt <= bitcnt_next;
      nz     <= nz_next;
      rem    <= rem_next;
      quot   <= quot_next;
    end
  end

  // The read register doubles as the output payload; it only moves on a read.
  rdc_ram #(
    .WIDTH(rdc_pkg::DIGIT_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(rem_wr),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(digit)
  );

endmodule

/* hw/rtl/rdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* verif/radix_digit_converter_core_tb.sv */
// Self-checking testbench for the radix digit converter core.
module radix_digit_converter_core_tb;

  localparam int VBITS      = rdc_pkg::DEF_VALUE_BITS;
  localparam int DEPTH      = rdc_pkg::DEF_STACK_DEPTH;
  localparam int DW         = rdc_pkg::DIGIT_W;
  localparam int RW         = rdc_pkg::RADIX_W;
  localparam int CYCLE_CAP  = 1_500_000;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_ITEMS = 18;

  // Digit predictor and the queue of digits still owed by the block.
  class digit_scoreboard;
    logic [rdc_pkg::RADIX_W-1:0] radix;
    bit [rdc_pkg::DIGIT_W-1:0]   owed_digit[$];
    bit                          owed_last[$];
    int errors;
    int values_seen;
    int digits_seen;

    function new();
      radix = rdc_pkg::RADIX_RESET;
      errors = 0;
      values_seen = 0;
      digits_seen = 0;
    endfunction

    function int pending();
      return owed_digit.size();
    endfunction

    // Divide down, then unwind the remainders so the top digit comes out first.
    function void note_value(logic [VBITS-1:0] v);
      bit [rdc_pkg::DIGIT_W-1:0] stack[DEPTH];
      int unsigned depth;
      int unsigned base;
      logic [VBITS-1:0] quot;
      base = 32'(radix);
      if (base < 32'(rdc_pkg::RADIX_MIN)) base = 32'(rdc_pkg::RADIX_MIN);
      if (base > 32'(rdc_pkg::RADIX_MAX)) base = 32'(rdc_pkg::RADIX_MAX);
      quot = v;
      depth = 0;
      do begin
        if (depth >= DEPTH) break;
        stack[depth] = DW'(quot % base);
        depth++;
        quot = VBITS'(quot / base);
      end while (quot != 0);
      while (depth > 0) begin
        depth--;
        owed_digit.push_back(stack[depth]);
        owed_last.push_back(depth == 0);
      end
      values_seen++;
    endfunction

    task report(string msg);
      if (errors < 50) $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_digit(logic [rdc_pkg::DIGIT_W-1:0] d, logic l);
      bit [rdc_pkg::DIGIT_W-1:0] want_d;
      bit want_l;
      digits_seen++;
      if (owed_digit.size() == 0) begin
        report($sformatf("unexpected digit %0d last %0b", d, l));
      end else begin
        want_d = owed_digit.pop_front();
        want_l = owed_last.pop_front();
        if (d !== want_d) report($sformatf("digit %0d, expected %0d", d, want_d));
        if (l !== want_l) report($sformatf("last %0b, expected %0b", l, want_l));
      end
    endtask
  endclass

  logic                        clk;
  logic                        rst;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [rdc_pkg::RADIX_W-1:0] cfg_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [VBITS-1:0]            value;
  logic                        out_valid;
  logic                        out_stall;
  logic [rdc_pkg::DIGIT_W-1:0] digit;
  logic                        last;

  digit_scoreboard sb;
  int idle_odds;   // percent chance of an idle burst per beat, per side
  int cycles;
  int radix_writes;
  int stall_left;

  radix_digit_converter_core #(
    .VALUE_BITS (VBITS),
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .digit    (digit),
    .last     (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure in bursts.
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_digit(digit, last);
  end

  // Called just after a falling edge; leaves valid high on return.
  task send_value(logic [VBITS-1:0] v);
    if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid = 1'b1;
    value = v;
    do @(posedge clk); while (in_stall);
    sb.note_value(v);
    @(negedge clk);
  endtask

  task drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task write_radix(logic [rdc_pkg::RADIX_W-1:0] r);
    in_valid = 1'b0;
    drain();
    cfg_valid = 1'b1;
    cfg_data = r;
    do @(posedge clk); while (!cfg_ready);
    sb.radix = r;
    radix_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Mix of zero, tiny values, exact powers of the base and the values just
  // below them, all-ones, and random values of random length.
  function logic [VBITS-1:0] pick_value();
    logic [VBITS-1:0] v;
    longint pw;
    int unsigned base;
    int unsigned kind;
    base = 32'(sb.radix);
    if (base < 32'(rdc_pkg::RADIX_MIN)) base = 32'(rdc_pkg::RADIX_MIN);
    if (base > 32'(rdc_pkg::RADIX_MAX)) base = 32'(rdc_pkg::RADIX_MAX);
    kind = $urandom_range(0, 9);
    case (kind)
      0: v = '0;
      1: v = VBITS'($urandom_range(1, base * base));
      2: begin
        pw = 1;
        repeat ($urandom_range(1, 30)) begin
          if (pw * base < (64'd1 << VBITS)) pw = pw * base;
        end
        v = VBITS'(pw - $urandom_range(0, 1));
      end
      3: v = '1;
      default: v = VBITS'($urandom >> $urandom_range(0, 31));
    endcase
    return v;
  endfunction

  initial begin
    logic [rdc_pkg::RADIX_W-1:0] r;
    sb = new();
    cycles = 0;
    radix_writes = 0;
    idle_odds = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    value = '0;
    out_stall = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero, one, full scale, alternating bits, and base saturation.
    idle_odds = 10;
    write_radix(4'd2);
    send_value('0);
    send_value(31'd1);
    send_value('1);
    send_value(31'h4000_0000);
    send_value(31'h5555_5555);
    send_value(31'h2AAA_AAAA);
    write_radix(4'd9);
    send_value('0);
    send_value(31'd8);
    send_value(31'd9);
    send_value(31'd80);
    send_value('1);
    write_radix(4'd0);
    send_value(31'd5);
    send_value('1);
    write_radix(4'd1);
    send_value(31'd3);
    write_radix(4'd10);
    send_value(31'd9);
    send_value(31'd10);
    write_radix(4'd15);
    send_value(31'd728);
    send_value('1);
    write_radix(4'd7);
    send_value(31'd48);
    send_value(31'd49);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: r = 4'd2;
        1: r = 4'd9;
        2: r = 4'd0;
        3: r = 4'd15;
        4: r = 4'd1;
        5: r = 4'd10;
        default: r = RW'($urandom_range(0, 15));
      endcase
      write_radix(r);
      if (ph == RAND_PHASES - 1) idle_odds = 0;
      else case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 15;
        default: idle_odds = 45;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) send_value(pick_value());
    end

    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Converted %0d values into %0d digits across %0d radix writes.",
             sb.values_seen, sb.digits_seen, radix_writes);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
